// ===== design/shapad_pkg.sv =====
// ----------------------------------------------------------------------------
// shapad_pkg
// Shared constants and types for the SHA-256 message padder.
// ----------------------------------------------------------------------------
`default_nettype none

package shapad_pkg;

  // Fixed SHA-256 geometry
  localparam int unsigned WordBits        = 32;
  localparam int unsigned BlockBits       = 512;
  localparam int unsigned LenFieldStart   = 448;
  localparam int unsigned WordBytes       = WordBits / 8;
  localparam int unsigned BlockBytes      = BlockBits / 8;
  localparam int unsigned BlockWords      = BlockBits / WordBits;
  localparam int unsigned PosBits         = $clog2(BlockBytes);
  localparam int unsigned WordIdxBits     = $clog2(BlockWords);
  // Message length is counted in bytes; the low three bits of the bit length are zero
  localparam int unsigned ByteCntBits     = 61;

  // Word slots of the 64-bit length field
  localparam logic [WordIdxBits-1:0] LenHiIdx = 4'(LenFieldStart / WordBits);
  localparam logic [WordIdxBits-1:0] LenLoIdx = 4'(BlockWords - 1);
  // First pad word sits at or past this slot: the length spills into a new block
  localparam logic [WordIdxBits-1:0] SpillIdx = LenHiIdx;

  // Marker byte and zero fill
  localparam logic [7:0] PadMarker = 8'h80;

  // Start request from the byte packer to the pad sequencer
  typedef struct packed {
    logic                          start;
    logic [WordIdxBits-1:0]        first_idx;
    logic                          spill;
    logic [WordBits-1:0]           first_word;
    logic [ByteCntBits-1:0]        byte_cnt;
  } pad_start_t;

  // One pad word offered by the sequencer
  typedef struct packed {
    logic                          valid;
    logic [WordBits-1:0]           word;
    logic                          block_last;
    logic                          message_last;
  } pad_word_t;

endpackage

`default_nettype wire

// ===== design/shapad_pad_seq.sv =====
// ----------------------------------------------------------------------------
// shapad_pad_seq
// Emits the marker word, zero fill and length words after end of message.
// ----------------------------------------------------------------------------
`default_nettype none

module shapad_pad_seq
  import shapad_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pad_start_t start_i,
  input  wire logic       advance_i,
  output pad_word_t       pad_o
);

  logic                   active_q, active_d;
  logic                   first_q, first_d;
  logic                   spill_q, spill_d;
  logic [WordIdxBits-1:0] idx_q, idx_d;
  logic [WordBits-1:0]    first_word_q, first_word_d;
  logic [ByteCntBits-1:0] cnt_q, cnt_d;

  // Current word: marker word first, length in the last two slots, else zero
  always_comb begin
    pad_o.valid        = active_q;
    pad_o.block_last   = (idx_q == LenLoIdx);
    pad_o.message_last = !spill_q && (idx_q == LenLoIdx);
    if (first_q) begin
      pad_o.word = first_word_q;
    end else if (!spill_q && (idx_q == LenHiIdx)) begin
      pad_o.word = cnt_q[ByteCntBits-1:ByteCntBits-WordBits];
    end else if (!spill_q && (idx_q == LenLoIdx)) begin
      pad_o.word = {cnt_q[ByteCntBits-WordBits-1:0], 3'b000};
    end else begin
      pad_o.word = '0;
    end
  end

  // Sequencer next state
  always_comb begin
    active_d     = active_q;
    first_d      = first_q;
    spill_d      = spill_q;
    idx_d        = idx_q;
    first_word_d = first_word_q;
    cnt_d        = cnt_q;
    if (start_i.start) begin
      active_d     = 1'b1;
      first_d      = 1'b1;
      spill_d      = start_i.spill;
      idx_d        = start_i.first_idx;
      first_word_d = start_i.first_word;
      cnt_d        = start_i.byte_cnt;
    end else if (active_q && advance_i) begin
      first_d = 1'b0;
      idx_d   = idx_q + WordIdxBits'(1);
      if (idx_q == LenLoIdx) begin
        if (spill_q) begin
          spill_d = 1'b0;
        end else begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      first_q  <= 1'b0;
      spill_q  <= 1'b0;
      idx_q    <= '0;
    end else begin
      active_q <= active_d;
      first_q  <= first_d;
      spill_q  <= spill_d;
      idx_q    <= idx_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    first_word_q <= first_word_d;
    cnt_q        <= cnt_d;
  end

endmodule

`default_nettype wire

// ===== design/sha256_message_padder_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_message_padder_unit
// Packs message bytes into big-endian words and appends SHA-256 padding.
// ----------------------------------------------------------------------------
// A completed word appears at the output in the cycle after its last byte is
// accepted. One byte per cycle while streaming, unless the output stalls.
// After an end of message the pad sequencer emits 3 to 18 words, one per
// cycle as the sink takes them, and input is held off until the last one.
// Reset (rst_ni low, async) clears position, length and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_padder_unit
  import shapad_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                has_byte_i,
  input  wire logic                end_of_message_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [WordBits-1:0]      padded_word_o,
  output logic                     block_last_o,
  output logic                     message_last_o
);

  logic [PosBits-1:0]     pos_q, pos_d, pos_new;
  logic [ByteCntBits-1:0] cnt_q, cnt_d, cnt_new;
  logic [23:0]            partial_q, partial_d, partial_new;
  logic                   out_valid_q, out_valid_d;
  logic [WordBits-1:0]    out_word_q, out_word_d;
  logic                   out_blk_q, out_blk_d;
  logic                   out_msg_q, out_msg_d;

  logic                   in_accept, word_done, out_free, pad_adv;
  logic [WordBits-1:0]    marker_word;
  pad_start_t             pad_start;
  pad_word_t              pad_word;

  // Byte packer
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !pad_word.valid &&
                       !(out_valid_q && !out_ready_i && (pos_q[1:0] == 2'd3));
  assign in_accept   = in_valid_i && in_ready_o;
  assign word_done   = has_byte_i && (pos_q[1:0] == 2'd3);
  assign pos_new     = pos_q + {{(PosBits-1){1'b0}}, has_byte_i};
  assign cnt_new     = cnt_q + {{(ByteCntBits-1){1'b0}}, has_byte_i};
  assign partial_new = has_byte_i ? {partial_q[15:0], data_byte_i} : partial_q;

  // Word holding the leftover bytes followed by the marker
  always_comb begin
    case (pos_new[1:0])
      2'd1:    marker_word = {partial_new[7:0], PadMarker, 16'h0000};
      2'd2:    marker_word = {partial_new[15:0], PadMarker, 8'h00};
      2'd3:    marker_word = {partial_new[23:0], PadMarker};
      default: marker_word = {PadMarker, 24'h000000};
    endcase
  end

  always_comb begin
    pad_start.start      = in_accept && end_of_message_i;
    pad_start.first_idx  = pos_new[PosBits-1:2];
    pad_start.spill      = (pos_new[PosBits-1:2] >= SpillIdx);
    pad_start.first_word = marker_word;
    pad_start.byte_cnt   = cnt_new;
  end

  // Packer state: position and byte count return to zero after an end of message
  always_comb begin
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    partial_d = partial_q;
    if (in_accept) begin
      partial_d = partial_new;
      if (end_of_message_i) begin
        pos_d = '0;
        cnt_d = '0;
      end else begin
        pos_d = pos_new;
        cnt_d = cnt_new;
      end
    end
  end

  shapad_pad_seq u_pad_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (pad_start),
    .advance_i (pad_adv),
    .pad_o     (pad_word)
  );

  // Output register: pad words, else a word completed by the incoming byte
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    out_blk_d   = out_blk_q;
    out_msg_d   = out_msg_q;
    pad_adv     = 1'b0;
    if (out_free) begin
      if (pad_word.valid) begin
        out_valid_d = 1'b1;
        out_word_d  = pad_word.word;
        out_blk_d   = pad_word.block_last;
        out_msg_d   = pad_word.message_last;
        pad_adv     = 1'b1;
      end else if (in_accept && word_done) begin
        out_valid_d = 1'b1;
        out_word_d  = {partial_q, data_byte_i};
        out_blk_d   = (pos_new == '0);
        out_msg_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    partial_q  <= partial_d;
    out_word_q <= out_word_d;
    out_blk_q  <= out_blk_d;
    out_msg_q  <= out_msg_d;
  end

  assign out_valid_o    = out_valid_q;
  assign padded_word_o  = out_word_q;
  assign block_last_o   = out_blk_q;
  assign message_last_o = out_msg_q;

  // Checks
  a_msg_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_last_o |-> block_last_o)
    else $error("message end word not at end of block");

  a_no_input_while_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_word.valid |-> !in_ready_o)
    else $error("input taken while padding");

  a_end_starts_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && end_of_message_i |=> pad_word.valid && (pos_q == '0))
    else $error("end of message did not start padding");

  a_pad_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_word.valid && !pad_adv |=> pad_word.valid && $stable(pad_word.word))
    else $error("pad word changed while stalled");

endmodule

`default_nettype wire
